>>> rtl/hsi_pkg.sv
// ----------------------------------------------------------------------------
// hsi_pkg: shared types and constants for the heapsort block
// Store size, index widths, the datapath operation codes and the status
// bundle that the controller reads back from the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hsi_pkg;

  // Store capacity and derived widths
  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = ADDR_W + 1;

  // Datapath operations, one per controller state, plus OP_NONE
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_SB,
    OP_HELD,
    OP_CHK,
    OP_C0,
    OP_C1,
    OP_CMP,
    OP_NEXT,
    OP_SW0,
    OP_SW1,
    OP_SW2,
    OP_OUT
  } hsi_op_t;

  // Status from datapath to controller
  typedef struct packed {
    logic n_small;     // set holds fewer than two values
    logic child_out;   // left child falls beyond the heap limit
    logic has_right;   // right child lies inside the heap limit
    logic held_lt;     // held value is below the larger child
    logic sort_done;   // last extraction finished
    logic next_build;  // another build-phase sift follows
    logic out_done;    // final result is being read
  } hsi_stat_t;

endpackage : hsi_pkg

`default_nettype wire

>>> rtl/hsi_datapath.sv
// ----------------------------------------------------------------------------
// hsi_datapath: value store and sift-down datapath
// Holds the 64-entry store (one write, one registered read per cycle), the
// heap index registers, the held/child value registers and the result
// registers. Each cycle it carries out the operation the controller names.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_datapath
  import hsi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hsi_op_t           op,
  input  wire logic [DATA_W-1:0] in_value,
  output hsi_stat_t              stat,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_sorted_value,
  output logic                   out_last_out,
  output logic                   out_overflow
);

  // Store
  logic [DATA_W-1:0] mem [MAX_ITEMS];
  logic [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Set bookkeeping
  logic [CNT_W-1:0]  count_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  n_r;
  logic              extract_r;
  logic [ADDR_W-1:0] r_r;
  logic [ADDR_W-1:0] end_r;
  logic [ADDR_W-1:0] k_r;

  // Sift-down registers
  logic [ADDR_W-1:0] pos_r;
  logic [ADDR_W-1:0] child_r;
  logic [CNT_W-1:0]  limit_r;
  logic [DATA_W-1:0] held_r;
  logic [DATA_W-1:0] cval_r;
  logic [DATA_W-1:0] tmp_r;

  // Result registers
  logic              out_valid_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic [CNT_W-1:0]  child_w;
  logic              right_gt;

  // Heap index and compare logic
  always_comb begin
    child_w        = {pos_r, 1'b1};
    right_gt       = $signed(rd_data_r) > $signed(cval_r);
    stat.n_small   = count_r < CNT_W'(2);
    stat.child_out = child_w >= limit_r;
    stat.has_right = (CNT_W'(child_r) + CNT_W'(1)) < limit_r;
    stat.held_lt   = $signed(held_r) < $signed(cval_r);
    stat.sort_done = extract_r && (end_r == ADDR_W'(1));
    stat.next_build = !extract_r && (r_r != ADDR_W'(1));
    stat.out_done  = (CNT_W'(k_r) + CNT_W'(1)) == n_r;
  end

  // Read address select
  always_comb begin
    case (op)
      OP_SB:   rd_addr = r_r - ADDR_W'(1);
      OP_CHK:  rd_addr = child_w[ADDR_W-1:0];
      OP_C0:   rd_addr = child_r + ADDR_W'(1);
      OP_SW1:  rd_addr = end_r;
      OP_OUT:  rd_addr = k_r;
      default: rd_addr = '0;
    endcase
  end

  // Write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = held_r;
    case (op)
      OP_LOAD: begin
        wr_en   = count_r < CNT_W'(MAX_ITEMS);
        wr_addr = count_r[ADDR_W-1:0];
        wr_data = in_value;
      end
      OP_CHK: begin
        wr_en = stat.child_out;
      end
      OP_CMP: begin
        wr_en   = 1'b1;
        wr_data = stat.held_lt ? cval_r : held_r;
      end
      OP_SW2: begin
        wr_en   = 1'b1;
        wr_addr = end_r;
        wr_data = tmp_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (op == OP_OUT);
      if (op == OP_LOAD) begin
        if (count_r < CNT_W'(MAX_ITEMS)) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      // set is finished once its final result is read
      if (op == OP_OUT && stat.out_done) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_SETUP: begin
        n_r       <= count_r;
        r_r       <= count_r[CNT_W-1:1];
        extract_r <= 1'b0;
        k_r       <= '0;
      end
      OP_SB: begin
        pos_r   <= r_r - ADDR_W'(1);
        limit_r <= n_r;
      end
      OP_HELD: begin
        held_r <= rd_data_r;
      end
      OP_CHK: begin
        child_r <= child_w[ADDR_W-1:0];
      end
      OP_C0: begin
        cval_r <= rd_data_r;
      end
      OP_C1: begin
        // take the right child when it is larger
        if (right_gt) begin
          cval_r  <= rd_data_r;
          child_r <= child_r + ADDR_W'(1);
        end
      end
      OP_CMP: begin
        if (stat.held_lt) begin
          pos_r <= child_r;
        end
      end
      OP_NEXT: begin
        if (!extract_r) begin
          if (r_r == ADDR_W'(1)) begin
            extract_r <= 1'b1;
            end_r     <= n_r[ADDR_W-1:0] - ADDR_W'(1);
          end else begin
            r_r <= r_r - ADDR_W'(1);
          end
        end else begin
          end_r <= end_r - ADDR_W'(1);
        end
      end
      OP_SW1: begin
        tmp_r <= rd_data_r;
      end
      OP_SW2: begin
        // old last entry becomes the sifted root
        held_r  <= rd_data_r;
        pos_r   <= '0;
        limit_r <= CNT_W'(end_r);
      end
      OP_OUT: begin
        k_r        <= k_r + ADDR_W'(1);
        out_last_r <= stat.out_done;
        out_ovf_r  <= ovf_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = rd_data_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule : hsi_datapath

`default_nettype wire

>>> rtl/hsi_ctrl.sv
// ----------------------------------------------------------------------------
// hsi_ctrl: heapsort sequencer
// Steps through load, heap build, extraction and output, naming one datapath
// operation per cycle and branching on the datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_ctrl
  import hsi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      in_is_last,
  input  wire hsi_stat_t stat,
  output hsi_op_t        op,
  output logic           busy
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_SB,
    ST_HELD,
    ST_CHK,
    ST_C0,
    ST_C1,
    ST_CMP,
    ST_NEXT,
    ST_SW0,
    ST_SW1,
    ST_SW2,
    ST_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and operation
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      ST_LOAD: begin
        if (start) begin
          op = OP_LOAD;
          if (in_is_last) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        op        = OP_SETUP;
        state_nxt = stat.n_small ? ST_OUT : ST_SB;
      end
      ST_SB: begin
        op        = OP_SB;
        state_nxt = ST_HELD;
      end
      ST_HELD: begin
        op        = OP_HELD;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        op        = OP_CHK;
        state_nxt = stat.child_out ? ST_NEXT : ST_C0;
      end
      ST_C0: begin
        op        = OP_C0;
        state_nxt = stat.has_right ? ST_C1 : ST_CMP;
      end
      ST_C1: begin
        op        = OP_C1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        op        = OP_CMP;
        state_nxt = stat.held_lt ? ST_CHK : ST_NEXT;
      end
      ST_NEXT: begin
        op = OP_NEXT;
        if (stat.sort_done) begin
          state_nxt = ST_OUT;
        end else if (stat.next_build) begin
          state_nxt = ST_SB;
        end else begin
          state_nxt = ST_SW0;
        end
      end
      ST_SW0: begin
        op        = OP_SW0;
        state_nxt = ST_SW1;
      end
      ST_SW1: begin
        op        = OP_SW1;
        state_nxt = ST_SW2;
      end
      ST_SW2: begin
        op        = OP_SW2;
        state_nxt = ST_CHK;
      end
      ST_OUT: begin
        op = OP_OUT;
        if (stat.out_done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_LOAD);

endmodule : hsi_ctrl

`default_nettype wire

>>> rtl/heap_sort_integers.sv
// ----------------------------------------------------------------------------
// heap_sort_integers: heapsort of up to 64 signed 32-bit integers
//
// Input: a beat is taken on a rising edge with start high and busy low. Each
// beat carries in_value and in_is_last; a beat with in_is_last closes the set.
// Beats may come back to back. Beats past 64 values are dropped and the
// whole run is flagged with out_overflow.
// After the closing beat busy rises while the set is heap-ordered in place.
// Each sift-down level steps through the CHK, C0, C1 (only when a right child
// exists) and CMP states, sharing the single read port of the store.
// Results: out_valid strobes for one cycle per value, ascending, one value per
// cycle back to back; out_last_out marks the greatest. The receiver cannot
// stall. busy drops as the last result is read, so the next set may start
// while the final result is still on the ports.
// Reset (rst_n low, synchronous) empties the set and drops any run in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_integers
  import hsi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [DATA_W-1:0] in_value,
  input  wire logic              in_is_last,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_sorted_value,
  output logic                   out_last_out,
  output logic                   out_overflow
);

  hsi_op_t   op;
  hsi_stat_t stat;

  // Sequencer
  hsi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_is_last (in_is_last),
    .stat       (stat),
    .op         (op),
    .busy       (busy)
  );

  // Store and sift datapath
  hsi_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_value         (in_value),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

endmodule : heap_sort_integers

`default_nettype wire

>>> rtl/hsi_checker.sv
// ----------------------------------------------------------------------------
// hsi_checker: port-level checks for the heapsort block
// Results of a run come out back to back, in ascending order, with one
// overflow flag; a closing beat starts the sort; reset quiets the block.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_checker
  import hsi_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              in_is_last,
  input wire logic              out_valid,
  input wire logic [DATA_W-1:0] out_sorted_value,
  input wire logic              out_last_out,
  input wire logic              out_overflow
);

  // Results of one run come out on consecutive cycles
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_out |=> out_valid)
    else $error("result burst broken before last beat");

  // Ascending signed order within a run
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_out |=>
      $signed(out_sorted_value) >= $signed($past(out_sorted_value)))
    else $error("results not ascending");

  // Overflow flag is constant over a run
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_out |=> out_overflow == $past(out_overflow))
    else $error("overflow flag changed within a run");

  // Closing beat starts the sort
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_is_last |=> busy)
    else $error("busy not raised after closing beat");

  // Reset leaves the block ready and quiet
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule : hsi_checker

bind heap_sort_integers hsi_checker u_hsi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_is_last       (in_is_last),
  .out_valid        (out_valid),
  .out_sorted_value (out_sorted_value),
  .out_last_out     (out_last_out),
  .out_overflow     (out_overflow)
);

`default_nettype wire
